/* hw/rtl/mmsd_pkg.sv */
// ----------------------------------------------------------------------------
// mmsd_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the masked mean stereo depth block.
// ----------------------------------------------------------------------------
package mmsd_pkg;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned SCALE_W    = 32;
	localparam int unsigned CNT_W      = 21;
	localparam int unsigned SUM_W      = 52;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned DIV_STEPS  = 32;
	localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0]   MAX_PIXELS       = CNT_W'(1048576);
	localparam logic [SCALE_W-1:0] DEPTH_SCALE_RST  = SCALE_W'(1);
	localparam logic [CNT_W-1:0]   MIN_PIXELS_RST   = CNT_W'(100);

	localparam logic [IDX_W-1:0] REG_DEPTH_SCALE = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_MIN_PIXELS  = IDX_W'(1);

	typedef struct packed {
		logic capture;    // latch the pixel request
		logic div_pix;    // load divider with depth_scale / disparity
		logic div_mean;   // load divider with depth_sum / moving_count
		logic div_step;   // one restoring step
		logic count_inc;  // count a moving pixel
		logic sum_add;    // add divider quotient to the sum
		logic load_out;   // fill the result register and clear the frame
	} mmsd_cmd_t;

	typedef struct packed {
		logic moving;
		logic disp_zero;
		logic last;
		logic div_last;
		logic need_div;
		logic out_busy;
	} mmsd_sts_t;

endpackage

/* hw/rtl/mmsd_ctrl.sv */
// ----------------------------------------------------------------------------
// mmsd_ctrl
// Sequencer: takes one pixel request at a time and steps the datapath
// through the per-pixel division, accumulation and the frame-end mean.
// ----------------------------------------------------------------------------
module mmsd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mmsd_pkg::mmsd_sts_t sts,
	output mmsd_pkg::mmsd_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_LOAD    = 7'b0000010,
		S_DIVPIX  = 7'b0000100,
		S_ACCUM   = 7'b0001000,
		S_FINAL   = 7'b0010000,
		S_DIVMEAN = 7'b0100000,
		S_EMIT    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOAD;
				end
			end
			S_LOAD: begin
				if (sts.moving && !sts.disp_zero) begin
					cmd.div_pix = 1'b1;
					state_d     = S_DIVPIX;
				end else begin
					cmd.count_inc = sts.moving;
					state_d       = sts.last ? S_FINAL : S_IDLE;
				end
			end
			S_DIVPIX: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_ACCUM;
				end
			end
			S_ACCUM: begin
				cmd.sum_add   = 1'b1;
				cmd.count_inc = 1'b1;
				state_d       = sts.last ? S_FINAL : S_IDLE;
			end
			S_FINAL: begin
				if (sts.need_div) begin
					cmd.div_mean = 1'b1;
					state_d      = S_DIVMEAN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_DIVMEAN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				// hold until the result register is free
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/mmsd_dp.sv */
// ----------------------------------------------------------------------------
// mmsd_dp
// Datapath: configuration registers, frame accumulators, a shared
// one-bit-per-cycle restoring divider and the result register.
// ----------------------------------------------------------------------------
module mmsd_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mmsd_pkg::mmsd_cmd_t                    cmd,
	output mmsd_pkg::mmsd_sts_t                    sts,
	input  logic [mmsd_pkg::PIX_W-1:0]             motion_level,
	input  logic [mmsd_pkg::PIX_W-1:0]             disparity,
	input  logic                                   frame_end,
	input  logic                                   cfg_wr,
	input  logic [mmsd_pkg::IDX_W-1:0]             cfg_index,
	input  logic [mmsd_pkg::SCALE_W-1:0]           cfg_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mmsd_pkg::SCALE_W-1:0]           mean_depth,
	output logic [mmsd_pkg::CNT_W-1:0]             moving_pixels,
	output logic                                   too_few
);

	logic [mmsd_pkg::SCALE_W-1:0] depth_scale_q;
	logic [mmsd_pkg::CNT_W-1:0]   min_pixels_q;
	logic [mmsd_pkg::SUM_W-1:0]   sum_q;
	logic [mmsd_pkg::CNT_W-1:0]   count_q;

	logic                         moving_q;
	logic [mmsd_pkg::PIX_W-1:0]   disp_q;
	logic                         last_q;

	logic [mmsd_pkg::CNT_W-1:0]   rem_q;
	logic [mmsd_pkg::SCALE_W-1:0] quo_q;
	logic [mmsd_pkg::CNT_W-1:0]   dvsr_q;
	logic [mmsd_pkg::STEP_W-1:0]  step_q;

	logic                         out_valid_q;
	logic [mmsd_pkg::SCALE_W-1:0] mean_q;
	logic [mmsd_pkg::CNT_W-1:0]   pix_q;
	logic                         few_q;

	logic [mmsd_pkg::CNT_W:0]     trial;
	logic [mmsd_pkg::CNT_W:0]     diff;
	logic                         qbit;
	logic                         few;

	// restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[mmsd_pkg::SCALE_W-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign qbit  = !diff[mmsd_pkg::CNT_W];

	assign few = (count_q < min_pixels_q);

	assign sts.moving    = moving_q;
	assign sts.disp_zero = (disp_q == '0);
	assign sts.last      = last_q;
	assign sts.div_last  = (step_q == mmsd_pkg::STEP_W'(mmsd_pkg::DIV_STEPS - 1));
	assign sts.need_div  = !few && (count_q != '0);
	assign sts.out_busy  = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_scale_q <= mmsd_pkg::DEPTH_SCALE_RST;
			min_pixels_q  <= mmsd_pkg::MIN_PIXELS_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				mmsd_pkg::REG_DEPTH_SCALE: depth_scale_q <= cfg_data;
				mmsd_pkg::REG_MIN_PIXELS:  min_pixels_q  <= cfg_data[mmsd_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (cmd.load_out) begin
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.sum_add) begin
				sum_q <= sum_q + {{(mmsd_pkg::SUM_W - mmsd_pkg::SCALE_W){1'b0}}, quo_q};
			end
			if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			moving_q <= (motion_level != '0) && (count_q < mmsd_pkg::MAX_PIXELS);
			disp_q   <= disparity;
			last_q   <= frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_pix) begin
			rem_q  <= '0;
			quo_q  <= depth_scale_q;
			dvsr_q <= {{(mmsd_pkg::CNT_W - mmsd_pkg::PIX_W){1'b0}}, disp_q};
			step_q <= '0;
		end else if (cmd.div_mean) begin
			// the sum is below count * 2^32, so its upper bits start below the divisor
			rem_q  <= {1'b0, sum_q[mmsd_pkg::SUM_W-1:mmsd_pkg::SCALE_W]};
			quo_q  <= sum_q[mmsd_pkg::SCALE_W-1:0];
			dvsr_q <= count_q;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= qbit ? diff[mmsd_pkg::CNT_W-1:0] : trial[mmsd_pkg::CNT_W-1:0];
			quo_q  <= {quo_q[mmsd_pkg::SCALE_W-2:0], qbit};
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mean_q <= (!few && (count_q != '0)) ? quo_q : '0;
			pix_q  <= count_q;
			few_q  <= few;
		end
	end

	assign out_valid     = out_valid_q;
	assign mean_depth    = mean_q;
	assign moving_pixels = pix_q;
	assign too_few       = few_q;

endmodule

/* hw/rtl/masked_mean_stereo_depth.sv */
// ----------------------------------------------------------------------------
// masked_mean_stereo_depth
// Per-frame mean depth of moving pixels, depth = depth_scale / disparity.
//
//   channel   dir  handshake                 payload
//   s_*       in   s_tvalid / s_tready        tdata: motion_level, disparity;
//                                             tlast: frame_end
//   m_*       out  m_tvalid / m_tready        tdata: mean_depth, moving_pixels;
//                                             tuser: too_few
//   cfg_*     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A pixel skips the divider when it does not move or has zero disparity,
// and goes through the 32-step shared divider otherwise. The frame-end pixel
// then passes the final and emit states; the mean, when needed, uses the same divider.
// The result register frees the input once loaded; a stalled result holds
// only the frame end. Reset clears the sums and restores the register values.
// ----------------------------------------------------------------------------
module masked_mean_stereo_depth (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] motion_level, [15:8] disparity
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [31:0] mean_depth, [52:32] moving_pixels, zero pad
	output logic        m_tuser,   // [0] too_few
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	mmsd_pkg::mmsd_cmd_t cmd;
	mmsd_pkg::mmsd_sts_t sts;

	logic [mmsd_pkg::SCALE_W-1:0] mean_depth;
	logic [mmsd_pkg::CNT_W-1:0]   moving_pixels;

	assign cfg_ready = 1'b1;

	mmsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mmsd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.motion_level  (s_tdata[7:0]),
		.disparity     (s_tdata[15:8]),
		.frame_end     (s_tlast),
		.cfg_wr        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.mean_depth    (mean_depth),
		.moving_pixels (moving_pixels),
		.too_few       (m_tuser)
	);

	assign m_tdata = {3'b000, moving_pixels, mean_depth};

	a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a pixel is still in work");

	a_few_gives_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'd0))
		else $error("nonzero mean reported with too few moving pixels");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[52:32] <= mmsd_pkg::MAX_PIXELS))
		else $error("moving pixel count beyond its limit");

	a_divider_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.div_step)
		else $error("divider stepping while the input is open");

endmodule
